@@ sv/pvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared opcodes and constants for the pcm voice mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_PLAY  = 3'd1,
    OP_STOP  = 3'd2,
    OP_PAUSE = 3'd3,
    OP_VOL   = 3'd4,
    OP_QUERY = 3'd5,
    OP_TICK  = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  localparam logic [8:0]  UNITY_GAIN  = 9'd256;
  localparam logic [8:0]  MAX_GAIN    = 9'd384;
  localparam logic [15:0] NO_DURATION = 16'd60000;
  localparam logic [16:0] MAX_REGION  = 17'd65536;

endpackage
`default_nettype wire

@@ sv/pcm_voice_mixer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_voice_mixer_core
// Twelve-voice stereo pcm mixer with a frame store and one shared
// scale multiplier walked by a small sequencer.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall | op, address, samples, args
// out_    | output    | out_valid/out_stall | handle, query, mix fields
//
// load, stop, pause, play: decode, then output state; set volume: decode, S_VOL, output
// query: scan of the voices, then two reciprocal multiplies (S_QSCAN, S_QDIV)
// tick: select, store read, two scale steps and update per sounding voice;
// a silent voice passes only select; the registered store read needs S_TRD
// rst_n clears voice state; the store needs no clearing
// in_stall stays high while a word is in work or the result is untaken
// ----------------------------------------------------------------------------
module pcm_voice_mixer_core #(
  parameter int VOICE_COUNT    = 12,
  parameter int STORE_FRAMES   = 65536,
  parameter int SAMPLE_RATE_HZ = 44100
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_op,
  input  wire logic [15:0]        in_address,
  input  wire logic signed [15:0] in_left_in,
  input  wire logic signed [15:0] in_right_in,
  input  wire logic [16:0]        in_frame_count,
  input  wire logic               in_loop_flag,
  input  wire logic [15:0]        in_handle,
  input  wire logic               in_pause_flag,
  input  wire logic signed [10:0] in_arg_a,
  input  wire logic signed [10:0] in_arg_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             out_new_handle,
  output logic                    out_playing,
  output logic [10:0]             out_position_ms,
  output logic [15:0]             out_length_ms,
  output logic signed [15:0]      out_mix_left,
  output logic signed [15:0]      out_mix_right
);

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW = $clog2(STORE_FRAMES);
  // frames to ms: ceil(1000 * 2^36 / rate), exact for 17-bit frame counts
  localparam logic [33:0] Q_RECIP =
    34'(((64'd1000 << 36) + 64'(SAMPLE_RATE_HZ) - 64'd1) / 64'(SAMPLE_RATE_HZ));
  // percent * 64 / 25 by ceil(2^20 / 25)
  localparam logic [15:0] GAIN_RECIP = 16'd41944;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_VOL, S_QSCAN, S_QDIV, S_TSEL, S_TRD, S_TL, S_TR, S_TUPD,
    S_OUT
  } state_t;

  // sample store
  logic [31:0] store_mem [STORE_FRAMES];
  logic [31:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic        st_we;

  // voice state
  logic [15:0] v_handle_r [VOICE_COUNT];
  logic [15:0] v_start_r  [VOICE_COUNT];
  logic [16:0] v_len_r    [VOICE_COUNT];
  logic [16:0] v_pos_r    [VOICE_COUNT];
  logic [8:0]  v_gain_r   [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] v_loop_r, v_pause_r, v_act_r;
  logic [15:0] next_handle_r;

  // sequencer and captured word
  state_t      state_r;
  logic [2:0]  op_r;
  logic [15:0] addr_r, hnd_r;
  logic [31:0] frame_r;
  logic [16:0] cnt_r;
  logic        loop_r, pflag_r;
  logic signed [10:0] a_r, b_r;
  logic [VW-1:0] vi_r;
  logic signed [16:0] accl_r, accr_r;
  logic        dsel_r;   // 0 position, 1 length
  logic [16:0] qpos_r, qlen_r;

  // result register
  logic        ov_r;
  logic [15:0] o_nh_r, o_dur_r;
  logic        o_play_r;
  logic [10:0] o_pos_r;
  logic [15:0] o_l_r, o_r_r;

  // shared scale unit: sample times gain, truncate toward zero
  logic signed [15:0] mul_s;
  logic signed [25:0] mul_p;
  logic signed [17:0] scaled;
  logic signed [17:0] sum_w;
  logic signed [16:0] sat_w;
  logic        cur_is_l;

  assign cur_is_l = (state_r == S_TL);
  assign mul_s  = cur_is_l ? $signed(rd_data_r[15:0]) : $signed(rd_data_r[31:16]);
  assign mul_p  = mul_s * $signed({1'b0, v_gain_r[vi_r]});
  assign scaled = 18'(mul_p[25] ? (mul_p + 26'sd255) >>> 8 : mul_p >>> 8);
  assign sum_w  = (cur_is_l ? 18'(accl_r) : 18'(accr_r)) + scaled;
  assign sat_w  = (sum_w > 18'sd32767) ? 17'sd32767 :
                  (sum_w < -18'sd32768) ? -17'sd32768 : 17'(sum_w);

  // frames to ms by reciprocal multiply, position first then length
  logic [16:0] q_val;
  logic [50:0] q_prod;
  logic [14:0] q_ms;
  assign q_val  = dsel_r ? qlen_r : qpos_r;
  assign q_prod = q_val * Q_RECIP;
  assign q_ms   = q_prod[50:36];

  // volume decode
  logic signed [10:0] th_w, pct_w;
  logic [13:0] pct_x64;
  logic [28:0] g_prod;
  logic [8:0]  g_w;
  always_comb begin
    th_w  = a_r;
    pct_w = b_r;
    if (a_r > 11'sd16 && b_r <= 11'sd16) begin
      th_w  = b_r;
      pct_w = a_r;
    end
    // only percents below 150 reach the product, higher ones cap
    pct_x64 = {pct_w[7:0], 6'd0};
    g_prod  = pct_x64 * GAIN_RECIP;
    if (pct_w <= 11'sd0) g_w = pvm_pkg::UNITY_GAIN;
    else if (pct_w >= 11'sd150) g_w = pvm_pkg::MAX_GAIN;
    else g_w = g_prod[28:20];
  end

  // first idle voice
  logic [VW-1:0] free_w;
  always_comb begin
    free_w = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--)
      if (!v_act_r[v]) free_w = VW'(v);
  end

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign rd_addr  = AW'(v_start_r[vi_r] + v_pos_r[vi_r]);
  assign st_we    = (state_r == S_DEC) && (op_r == pvm_pkg::OP_LOAD);

  // store port
  always_ff @(posedge clk) begin
    if (st_we) store_mem[AW'(addr_r)] <= frame_r;
    rd_data_r <= store_mem[rd_addr];
  end

  logic        last_v;
  assign last_v = (32'(vi_r) == VOICE_COUNT - 1);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ov_r          <= 1'b0;
      next_handle_r <= 16'd1;
      v_act_r       <= '0;
      v_pause_r     <= '0;
      v_loop_r      <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        v_handle_r[v] <= '0;
        v_start_r[v]  <= '0;
        v_len_r[v]    <= '0;
        v_pos_r[v]    <= '0;
        v_gain_r[v]   <= pvm_pkg::UNITY_GAIN;
      end
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r    <= in_op;
            addr_r  <= in_address;
            frame_r <= {in_right_in, in_left_in};
            cnt_r   <= in_frame_count;
            loop_r  <= in_loop_flag;
            hnd_r   <= in_handle;
            pflag_r <= in_pause_flag;
            a_r     <= in_arg_a;
            b_r     <= in_arg_b;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          o_nh_r   <= '0;
          o_play_r <= 1'b0;
          o_pos_r  <= '0;
          o_dur_r  <= '0;
          o_l_r    <= '0;
          o_r_r    <= '0;
          vi_r     <= '0;
          accl_r   <= '0;
          accr_r   <= '0;
          state_r  <= S_OUT;
          unique case (op_r) inside
            pvm_pkg::OP_PLAY: begin
              if (next_handle_r == 16'd0) begin
                o_nh_r        <= 16'd1;
                next_handle_r <= 16'd2;
              end else begin
                o_nh_r        <= next_handle_r;
                next_handle_r <= next_handle_r + 16'd1;
              end
              if (cnt_r != 17'd0) begin
                v_handle_r[free_w] <= (next_handle_r == 16'd0) ? 16'd1 : next_handle_r;
                v_start_r[free_w]  <= addr_r;
                v_len_r[free_w]    <= (cnt_r > pvm_pkg::MAX_REGION) ?
                                      pvm_pkg::MAX_REGION : cnt_r;
                v_pos_r[free_w]    <= '0;
                v_gain_r[free_w]   <= pvm_pkg::UNITY_GAIN;
                v_act_r[free_w]    <= 1'b1;
                v_pause_r[free_w]  <= 1'b0;
                v_loop_r[free_w]   <= loop_r;
              end
            end
            pvm_pkg::OP_STOP, pvm_pkg::OP_PAUSE: begin
              for (int v = 0; v < VOICE_COUNT; v++)
                if (hnd_r == 16'd0 || v_handle_r[v] == hnd_r) begin
                  if (op_r == pvm_pkg::OP_STOP) v_act_r[v] <= 1'b0;
                  else v_pause_r[v] <= pflag_r;
                end
            end
            pvm_pkg::OP_VOL: state_r <= S_VOL;
            pvm_pkg::OP_QUERY: begin
              o_dur_r <= pvm_pkg::NO_DURATION;
              state_r <= S_QSCAN;
            end
            pvm_pkg::OP_TICK: state_r <= S_TSEL;
            default: ;
          endcase
        end
        // gain applied in its own state after decode so the percent scaling stays off the decode path
        S_VOL: begin
          if (!th_w[10])
            for (int v = 0; v < VOICE_COUNT; v++)
              if (v_act_r[v] && (th_w == 11'sd0 || v_handle_r[v] == 16'(th_w)))
                v_gain_r[v] <= g_w;
          state_r <= S_OUT;
        end
        // find the first active matching voice, one per cycle
        S_QSCAN: begin
          if (v_act_r[vi_r] && (hnd_r == 16'd0 || v_handle_r[vi_r] == hnd_r)) begin
            o_play_r <= 1'b1;
            qpos_r   <= v_pos_r[vi_r];
            qlen_r   <= v_len_r[vi_r];
            dsel_r   <= 1'b0;
            state_r  <= S_QDIV;
          end else if (last_v) begin
            state_r <= S_OUT;
          end else begin
            vi_r <= vi_r + VW'(1);
          end
        end
        // position in ms, then length in ms
        S_QDIV: begin
          if (!dsel_r) begin
            o_pos_r <= q_ms[10:0];
            dsel_r  <= 1'b1;
          end else begin
            o_dur_r <= (q_ms == 15'd0) ? pvm_pkg::NO_DURATION : 16'(q_ms);
            state_r <= S_OUT;
          end
        end
        // tick: skip idle or paused voices, wrap or end, then read the frame
        S_TSEL: begin
          if (v_act_r[vi_r] && !v_pause_r[vi_r]) begin
            if (v_pos_r[vi_r] >= v_len_r[vi_r]) begin
              if (v_loop_r[vi_r]) begin
                v_pos_r[vi_r] <= '0;
                state_r <= S_TRD;
              end else begin
                v_act_r[vi_r] <= 1'b0;
                state_r <= last_v ? S_OUT : S_TSEL;
                vi_r    <= last_v ? vi_r : vi_r + VW'(1);
              end
            end else begin
              state_r <= S_TRD;
            end
          end else begin
            state_r <= last_v ? S_OUT : S_TSEL;
            vi_r    <= last_v ? vi_r : vi_r + VW'(1);
          end
        end
        S_TRD: state_r <= S_TL;
        S_TL: begin
          accl_r  <= sat_w;
          state_r <= S_TR;
        end
        S_TR: begin
          accr_r  <= sat_w;
          state_r <= S_TUPD;
        end
        S_TUPD: begin
          v_pos_r[vi_r] <= v_pos_r[vi_r] + 17'd1;
          state_r <= last_v ? S_OUT : S_TSEL;
          vi_r    <= last_v ? vi_r : vi_r + VW'(1);
        end
        S_OUT: begin
          if (op_r == pvm_pkg::OP_TICK) begin
            o_l_r <= accl_r[15:0];
            o_r_r <= accr_r[15:0];
          end
          ov_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_new_handle  = o_nh_r;
  assign out_playing     = o_play_r;
  assign out_position_ms = o_pos_r;
  assign out_length_ms   = o_dur_r;
  assign out_mix_left    = o_l_r;
  assign out_mix_right   = o_r_r;

endmodule
`default_nettype wire

@@ sv/pvm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pvm_checker
// Port-level checks on the mixer core handshake and result words.
// ----------------------------------------------------------------------------
module pvm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_new_handle,
  input wire logic [15:0] out_mix_left
);

  // one word in work at a time: no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // accepted word blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after accept");

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_mix_left)
      && $stable(out_new_handle))) else $error("result dropped or changed");

  // result valid is low just after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

endmodule

bind pcm_voice_mixer_core pvm_checker u_pvm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_new_handle(out_new_handle), .out_mix_left(out_mix_left)
);
`default_nettype wire
